>>> rtl/bitmap_text_renderer_macros.svh
// ----------------------------------------------------------------------------
// bitmap_text_renderer_macros
// assertion macros used by the text renderer top level
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_RENDERER_MACROS_SVH
`define BITMAP_TEXT_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BTR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("btr assertion failed");

// next-cycle implication
`define BTR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("btr assertion failed");

`else

`define BTR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define BTR_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// types and constants of the bitmap text renderer
// ----------------------------------------------------------------------------
`default_nettype none

package btr_pkg;

  localparam int GLYPH_CODES = 256;
  localparam int GLYPH_DOTS  = 8;
  localparam int IDX_W       = $clog2(GLYPH_CODES);
  localparam int DOT_N       = GLYPH_DOTS * GLYPH_DOTS;
  localparam int DOT_IDX_W   = $clog2(DOT_N);
  localparam int XY_W        = $clog2(GLYPH_DOTS);
  localparam int DEF_WIDTH   = (8 > GLYPH_DOTS) ? GLYPH_DOTS : 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] NL_CODE = 8'd10;
  localparam logic [7:0] SP_CODE = 8'd32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef enum logic [2:0] {
    REG_FONT_HEIGHT,
    REG_COLUMN_GAP,
    REG_ROW_GAP,
    REG_ANCHOR_X,
    REG_ANCHOR_Y,
    REG_WRAP_WIDTH,
    REG_WRAP_ENABLE,
    REG_PIXEL_COLOR
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_GLYPH,
    CMD_NEWLINE,
    CMD_MOVE
  } cmd_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic        text_start;
    logic [3:0]  glyph_width;
    logic [63:0] glyph_rows;
  } item_t;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic [3:0]  font_height;
    logic [7:0]  column_gap;
    logic [7:0]  row_gap;
    logic [7:0]  anchor_x;
    logic [7:0]  anchor_y;
    logic [7:0]  wrap_width;
    logic        wrap_enable;
    logic [15:0] pixel_color;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  code;
    logic        text_start;
    logic        space;
    logic [3:0]  width;
    logic [63:0] rows;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/btr_front.sv
// ----------------------------------------------------------------------------
// btr_front
// accepts input items, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module btr_front (
  input  logic          clk,
  input  logic          rst,
  input  btr_pkg::item_t item,
  input  logic          push,
  output logic          full,
  output btr_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import btr_pkg::*;

  cmd_t              fresh;
  logic              keep;
  logic              in_range;
  logic              wr_en;
  cmd_t              queue_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    in_range         = 9'(item.char_code) < 9'(GLYPH_CODES);
    fresh.code       = item.char_code;
    fresh.text_start = item.text_start;
    fresh.space      = item.char_code == SP_CODE;
    fresh.width      = (item.glyph_width > 4'(GLYPH_DOTS)) ? 4'(GLYPH_DOTS) : item.glyph_width;
    fresh.rows       = item.glyph_rows;
    keep             = 1'b1;
    if (item.req_type == REQ_LOAD) begin
      fresh.kind = CMD_LOAD;
      keep       = in_range;
    end else if (!in_range) begin
      fresh.kind = CMD_MOVE;
    end else if (item.char_code == NL_CODE) begin
      fresh.kind = CMD_NEWLINE;
    end else begin
      fresh.kind = CMD_GLYPH;
    end
  end

  assign full      = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = queue_mem[rd_ptr];
  assign wr_en     = push && !full && keep;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_ptr] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/btr_back.sv
// ----------------------------------------------------------------------------
// btr_back
// glyph table, cursor and dot scan; while the output slot is free, at most one pixel transfer per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module btr_back (
  input  logic           clk,
  input  logic           rst,
  input  btr_pkg::cfg_t   cfg,
  input  btr_pkg::cmd_t   cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output btr_pkg::pixel_t pixel,
  output logic           empty,
  input  logic           pop
);
  import btr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_SCAN
  } state_t;

  state_t               state;
  logic [63:0]          rows_mem  [GLYPH_CODES];
  logic [3:0]           width_mem [GLYPH_CODES];
  logic [GLYPH_CODES-1:0] glyph_valid;
  logic [63:0]          rd_rows;
  logic [3:0]           rd_width;
  logic                 rd_valid;
  logic [IDX_W-1:0]     addr;
  logic                 mem_we;
  logic                 rd_en;
  logic [7:0]           cursor_col;
  logic [7:0]           cursor_row;
  logic [3:0]           glyph_w;
  logic                 is_space;
  logic [DOT_N-1:0]     rem;
  logic [DOT_N-1:0]     rem_after;
  logic [DOT_N-1:0]     dot_mask;
  logic [DOT_IDX_W-1:0] dot_idx;
  logic [XY_W-1:0]      dot_x;
  logic [XY_W-1:0]      dot_y;
  logic                 out_valid;
  pixel_t               out_pix;
  logic                 slot_free;
  logic                 lit;
  logic                 emit;
  logic [3:0]           eff_h;
  logic [3:0]           cur_w;
  logic [63:0]          cur_rows;
  logic [7:0]           start_col;
  logic [7:0]           start_row;
  logic [7:0]           base_col;
  logic [7:0]           advance_col;
  logic [7:0]           line_row;
  logic [8:0]           reach;
  logic [8:0]           limit;
  logic                 wrap_hit;

  assign addr    = cmd.code[IDX_W-1:0];
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign mem_we  = cmd_pop && (cmd.kind == CMD_LOAD);
  assign rd_en   = cmd_pop && (cmd.kind == CMD_GLYPH);

  always_comb begin
    eff_h       = (cfg.font_height > 4'(GLYPH_DOTS)) ? 4'(GLYPH_DOTS) : cfg.font_height;
    cur_w       = rd_valid ? rd_width : 4'(DEF_WIDTH);
    cur_rows    = rd_valid ? rd_rows : '1;
    start_col   = cmd.text_start ? cfg.anchor_x : cursor_col;
    start_row   = cmd.text_start ? cfg.anchor_y : cursor_row;
    line_row    = cursor_row + 8'(eff_h) + cfg.row_gap;
    reach       = {1'b0, cursor_col} + 9'(cur_w);
    limit       = {1'b0, cfg.wrap_width} + {1'b0, cfg.anchor_x};
    wrap_hit    = cfg.wrap_enable && (reach > limit);
    base_col    = wrap_hit ? cfg.anchor_x : cursor_col;
    advance_col = base_col + 8'(cur_w) + cfg.column_gap;
    slot_free   = !out_valid || pop;
    lit         = rem[dot_idx];
    emit        = (state == ST_SCAN) && lit && slot_free;
    rem_after   = rem;
    rem_after[dot_idx] = 1'b0;
  end

  // lit dots of the visible glyph area, row-major
  always_comb begin : mask_build
    logic [3:0] bidx;
    logic [7:0] row_byte;
    dot_mask = '0;
    for (int yy = 0; yy < GLYPH_DOTS; yy++) begin
      for (int xx = 0; xx < GLYPH_DOTS; xx++) begin
        row_byte = cur_rows[8*yy +: 8];
        bidx     = cur_w - 4'(xx) - 4'd1;
        if ((4'(yy) < eff_h) && (4'(xx) < cur_w)) begin
          dot_mask[yy*GLYPH_DOTS + xx] = row_byte[bidx[2:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rows_mem[addr]  <= cmd.rows;
      width_mem[addr] <= cmd.width;
    end
    if (rd_en) begin
      rd_rows  <= rows_mem[addr];
      rd_width <= width_mem[addr];
      rd_valid <= glyph_valid[addr];
    end
  end

  // unwritten entries read as a solid block
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= '0;
    end else if (mem_we) begin
      glyph_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              CMD_LOAD: begin
                state <= ST_IDLE;
              end
              CMD_MOVE: begin
                cursor_col <= start_col;
                cursor_row <= start_row;
              end
              CMD_NEWLINE: begin
                cursor_col <= cfg.anchor_x;
                cursor_row <= start_row + 8'(eff_h) + cfg.row_gap;
              end
              CMD_GLYPH: begin
                cursor_col <= start_col;
                cursor_row <= start_row;
                is_space   <= cmd.space;
                state      <= ST_GLYPH;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_GLYPH: begin
          glyph_w <= cur_w;
          rem     <= dot_mask;
          dot_idx <= '0;
          dot_x   <= '0;
          dot_y   <= '0;
          if (wrap_hit) begin
            cursor_row <= line_row;
          end
          if (wrap_hit && is_space) begin
            cursor_col <= cfg.anchor_x;
            state      <= ST_IDLE;
          end else if (is_space || (dot_mask == '0)) begin
            cursor_col <= advance_col;
            state      <= ST_IDLE;
          end else begin
            cursor_col <= base_col;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!lit || slot_free) begin
            if (lit) begin
              out_pix <= '{pixel_x: cursor_col + 8'(dot_x),
                           pixel_y: cursor_row + 8'(dot_y),
                           color:   cfg.pixel_color,
                           last:    rem_after == '0};
            end
            rem     <= rem_after;
            dot_idx <= dot_idx + 1'b1;
            if (dot_x == XY_W'(GLYPH_DOTS - 1)) begin
              dot_x <= '0;
              dot_y <= dot_y + 1'b1;
            end else begin
              dot_x <= dot_x + 1'b1;
            end
            if (rem_after == '0) begin
              cursor_col <= cursor_col + 8'(glyph_w) + cfg.column_gap;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pixel = out_pix;
  assign empty = !out_valid;

endmodule

`default_nettype wire

>>> rtl/bitmap_text_renderer.sv
// ----------------------------------------------------------------------------
// bitmap_text_renderer
// proportional bitmap font text renderer: character codes in, pixels out
// ----------------------------------------------------------------------------
// channel   ports                           transfer when
// input     item, push, full                push && !full
// result    pixel, empty, pop               pop && !empty
// config    cfg_write, cfg_addr, cfg_data   cfg_write
//
// a glyph load or a newline is handled in the idle state of the back end
// a drawn character passes the glyph state, then scans each dot position up
// to its last lit dot (at most GLYPH_DOTS * GLYPH_DOTS); the scan waits on pop
// reset is synchronous; the glyph table reads as solid blocks until loaded
// a four-entry command queue keeps taking items while the back end stalls on pop
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_text_renderer_macros.svh"

module bitmap_text_renderer (
  input  logic            clk,
  input  logic            rst,
  input  btr_pkg::item_t  item,
  input  logic            push,
  output logic            full,
  output btr_pkg::pixel_t pixel,
  output logic            empty,
  input  logic            pop,
  input  logic            cfg_write,
  input  logic [2:0]      cfg_addr,
  input  logic [15:0]     cfg_data
);
  import btr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{font_height: 4'd5, column_gap: 8'd2, row_gap: 8'd1,
               anchor_x: 8'd0, anchor_y: 8'd0, wrap_width: 8'd95,
               wrap_enable: 1'b0, pixel_color: 16'hFFFF};
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_addr))
        REG_FONT_HEIGHT: cfg.font_height <= cfg_data[3:0];
        REG_COLUMN_GAP:  cfg.column_gap  <= cfg_data[7:0];
        REG_ROW_GAP:     cfg.row_gap     <= cfg_data[7:0];
        REG_ANCHOR_X:    cfg.anchor_x    <= cfg_data[7:0];
        REG_ANCHOR_Y:    cfg.anchor_y    <= cfg_data[7:0];
        REG_WRAP_WIDTH:  cfg.wrap_width  <= cfg_data[7:0];
        REG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        REG_PIXEL_COLOR: cfg.pixel_color <= cfg_data;
        default:         cfg             <= cfg;
      endcase
    end
  end

  btr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  btr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop)
  );

  `BTR_ASSERT_IMP(a_pop_needs_cmd, clk, rst, cmd_pop, cmd_valid)
  `BTR_ASSERT_NXT(a_full_holds, clk, rst, full && !cmd_pop, full)

endmodule

`default_nettype wire
